>>> src/rpy_pose_to_rotation_matrix_macros.svh
// assertion macros for the rpy pose to rotation matrix block
// used by files that carry concurrent checks
`ifndef RPY_POSE_TO_ROTATION_MATRIX_MACROS_SVH
`define RPY_POSE_TO_ROTATION_MATRIX_MACROS_SVH
`ifndef ASSERT_OFF
`define RPY_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RPY_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RPY_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPY_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> src/rpy_pkg.sv
// package for the rpy pose to rotation matrix block
// payload types, cordic constants and arctangent table; no dependencies
`timescale 1ns / 1ps
package rpy_pkg;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;
	localparam int TABLE_LEN           = 24;
	localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] rot_z_angle;
		logic signed [15:0] rot_y_angle;
		logic signed [15:0] rot_x_angle;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] n_x;
		logic signed [15:0] n_y;
		logic signed [15:0] n_z;
		logic signed [15:0] o_x;
		logic signed [15:0] o_y;
		logic signed [15:0] o_z;
		logic signed [15:0] a_x;
		logic signed [15:0] a_y;
		logic signed [15:0] a_z;
		logic signed [31:0] p_x;
		logic signed [31:0] p_y;
		logic signed [31:0] p_z;
	} matrix_t;

	// one cordic lane: x, y in q30, z in 2^-32 turn
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		logic               flip;
	} lane_t;

	typedef lane_t [2:0] lanes_t;

	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sd536870912;  1: r = 34'sd316933406;
			2: r = 34'sd167458907;  3: r = 34'sd85004756;
			4: r = 34'sd42667331;   5: r = 34'sd21354465;
			6: r = 34'sd10679838;   7: r = 34'sd5340245;
			8: r = 34'sd2670163;    9: r = 34'sd1335087;
			10: r = 34'sd667544;    11: r = 34'sd333772;
			12: r = 34'sd166886;    13: r = 34'sd83443;
			14: r = 34'sd41722;     15: r = 34'sd20861;
			16: r = 34'sd10430;     17: r = 34'sd5215;
			18: r = 34'sd2608;      19: r = 34'sd1304;
			20: r = 34'sd652;       21: r = 34'sd326;
			22: r = 34'sd163;       23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

>>> src/rpy_cordic_cell.sv
// one cordic micro-rotation cell for three angle lanes with a pose carry
// depends on rpy_pkg
`timescale 1ns / 1ps
module rpy_cordic_cell import rpy_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vld_in,
	input  lanes_t lanes_in,
	input  pose_t  pose_in,
	output logic   vld_out,
	output lanes_t lanes_out,
	output pose_t  pose_out
);
	lanes_t nxt;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].flip = lanes_in[k].flip;
			if (!lanes_in[k].z[33]) begin
				nxt[k].x = lanes_in[k].x - (lanes_in[k].y >>> STAGE);
				nxt[k].y = lanes_in[k].y + (lanes_in[k].x >>> STAGE);
				nxt[k].z = lanes_in[k].z - atan_turn(STAGE);
			end else begin
				nxt[k].x = lanes_in[k].x + (lanes_in[k].y >>> STAGE);
				nxt[k].y = lanes_in[k].y - (lanes_in[k].x >>> STAGE);
				nxt[k].z = lanes_in[k].z + atan_turn(STAGE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_out <= nxt;
			pose_out  <= pose_in;
		end
	end
endmodule

>>> src/rpy_matrix.sv
// matrix entry products and sums after the cordic chain, with output saturation
// depends on rpy_pkg
`timescale 1ns / 1ps
module rpy_matrix import rpy_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    vld_in,
	input  lanes_t  lanes_in,
	input  pose_t   pose_in,
	output logic    vld_out,
	output matrix_t mat_out
);
	function automatic logic signed [33:0] fin(input logic signed [33:0] v, input logic f);
		logic signed [33:0] t;
		t = f ? -v : v;
		if (t > ONE_Q30) t = ONE_Q30;
		if (t < -ONE_Q30) t = -ONE_Q30;
		return t;
	endfunction

	function automatic logic signed [15:0] q14(input logic signed [62:0] v);
		logic signed [62:0] r;
		r = (v + (63'sd1 <<< 45)) >>> 46;
		if (r > 63'sd16384) r = 63'sd16384;
		if (r < -63'sd16384) r = -63'sd16384;
		return r[15:0];
	endfunction

	logic signed [31:0] s1_s1, c1_s1, s2_s1, c2_s1, s3_s1, c3_s1;
	logic signed [62:0] c1c2_s2, s1c2_s2, c2s3_s2, c2c3_s2, s1c3_s2, c1c3_s2;
	logic signed [62:0] s1s3_s2, c1s3_s2, ns2_s2;
	logic signed [31:0] c1s2_s2, s1s2_s2, s3_s2, c3_s2;
	logic signed [62:0] c1c2_s3, s1c2_s3, c2s3_s3, c2c3_s3, s1c3_s3, c1c3_s3;
	logic signed [62:0] s1s3_s3, c1s3_s3, ns2_s3, c1s2s3_s3, s1s2s3_s3, c1s2c3_s3, s1s2c3_s3;
	logic signed [33:0] tmp [6];
	logic [2:0] v_q;
	pose_t p1_q, p2_q, p3_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tmp[2*k]   = fin(lanes_in[k].y, lanes_in[k].flip);
			tmp[2*k+1] = fin(lanes_in[k].x, lanes_in[k].flip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], vld_in};
		end
	end
	assign vld_out = v_q[2];

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s1 <= tmp[0][31:0]; c1_s1 <= tmp[1][31:0];
			s2_s1 <= tmp[2][31:0]; c2_s1 <= tmp[3][31:0];
			s3_s1 <= tmp[4][31:0]; c3_s1 <= tmp[5][31:0];
			p1_q <= pose_in;

			c1c2_s2 <= 63'(c1_s1) * 63'(c2_s1);
			s1c2_s2 <= 63'(s1_s1) * 63'(c2_s1);
			c2s3_s2 <= 63'(c2_s1) * 63'(s3_s1);
			c2c3_s2 <= 63'(c2_s1) * 63'(c3_s1);
			s1c3_s2 <= 63'(s1_s1) * 63'(c3_s1);
			c1c3_s2 <= 63'(c1_s1) * 63'(c3_s1);
			s1s3_s2 <= 63'(s1_s1) * 63'(s3_s1);
			c1s3_s2 <= 63'(c1_s1) * 63'(s3_s1);
			ns2_s2  <= -(63'(s2_s1) <<< 30);
			c1s2_s2 <= 32'((63'(c1_s1) * 63'(s2_s1) + (63'sd1 <<< 29)) >>> 30);
			s1s2_s2 <= 32'((63'(s1_s1) * 63'(s2_s1) + (63'sd1 <<< 29)) >>> 30);
			s3_s2 <= s3_s1; c3_s2 <= c3_s1;
			p2_q <= p1_q;

			c1c2_s3 <= c1c2_s2; s1c2_s3 <= s1c2_s2; c2s3_s3 <= c2s3_s2;
			c2c3_s3 <= c2c3_s2; s1c3_s3 <= s1c3_s2; c1c3_s3 <= c1c3_s2;
			s1s3_s3 <= s1s3_s2; c1s3_s3 <= c1s3_s2; ns2_s3 <= ns2_s2;
			c1s2s3_s3 <= 63'(c1s2_s2) * 63'(s3_s2);
			s1s2s3_s3 <= 63'(s1s2_s2) * 63'(s3_s2);
			c1s2c3_s3 <= 63'(c1s2_s2) * 63'(c3_s2);
			s1s2c3_s3 <= 63'(s1s2_s2) * 63'(c3_s2);
			p3_q <= p2_q;
		end
	end

	always_comb begin
		mat_out.n_x = q14(c1c2_s3);
		mat_out.n_y = q14(s1c2_s3);
		mat_out.n_z = q14(ns2_s3);
		mat_out.o_x = q14(c1s2s3_s3 - s1c3_s3);
		mat_out.o_y = q14(s1s2s3_s3 + c1c3_s3);
		mat_out.o_z = q14(c2s3_s3);
		mat_out.a_x = q14(c1s2c3_s3 + s1s3_s3);
		mat_out.a_y = q14(s1s2c3_s3 - c1s3_s3);
		mat_out.a_z = q14(c2c3_s3);
		mat_out.p_x = p3_q.pos_x;
		mat_out.p_y = p3_q.pos_y;
		mat_out.p_z = p3_q.pos_z;
	end
endmodule

>>> src/rpy_pose_to_rotation_matrix.sv
// pipeline: front phase and fold registers, then the cordic cell chain, then the product registers
// throughput: one pose per cycle; every stage is a front register, a register of the cordic cell chain
// or the product pipeline, all advancing together while the output is not stalled
// reset: arst_n clears all valid flags asynchronously; payload registers are not reset
// top level: angle to phase, quadrant fold, cordic cell chain, matrix products
`timescale 1ns / 1ps
`include "rpy_pose_to_rotation_matrix_macros.svh"
module rpy_pose_to_rotation_matrix import rpy_pkg::*; #(
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  pose_t   in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output matrix_t out_data
);
	localparam int NST = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic          v_s1, v_s2;
	pose_t         pose_s1, pose_s2;
	logic [31:0]   ph_s1 [3];
	lanes_t        l_s2;
	logic          vc [NST+1];
	lanes_t        lc [NST+1];
	pose_t         pc [NST+1];
	logic signed [63:0] prod [3];
	logic signed [15:0] ang [3];

	assign ang[0] = in_data.rot_z_angle;
	assign ang[1] = in_data.rot_y_angle;
	assign ang[2] = in_data.rot_x_angle;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = 64'(ang[k]) * 64'(TURN_PER_RAD) + (64'sd1 <<< (ANGLE_FRAC_BITS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ph_s1[k] <= prod[k][ANGLE_FRAC_BITS +: 32];
			end
			pose_s1 <= in_data;
			for (int k = 0; k < 3; k++) begin
				l_s2[k].x <= CORDIC_GAIN;
				l_s2[k].y <= '0;
				if (ph_s1[k][31] != ph_s1[k][30]) begin
					l_s2[k].flip <= 1'b1;
					l_s2[k].z <= 34'($signed({~ph_s1[k][31], ph_s1[k][30:0]}));
				end else begin
					l_s2[k].flip <= 1'b0;
					l_s2[k].z <= 34'($signed(ph_s1[k]));
				end
			end
			pose_s2 <= pose_s1;
		end
	end

	assign vc[0] = v_s2;
	assign lc[0] = l_s2;
	assign pc[0] = pose_s2;

	for (genvar g = 0; g < NST; g++) begin : g_cell
		rpy_cordic_cell #(.STAGE(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(vc[g]), .lanes_in(lc[g]), .pose_in(pc[g]),
			.vld_out(vc[g+1]), .lanes_out(lc[g+1]), .pose_out(pc[g+1])
		);
	end

	rpy_matrix u_matrix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_in(vc[NST]), .lanes_in(lc[NST]), .pose_in(pc[NST]),
		.vld_out(out_valid), .mat_out(out_data)
	);

	`RPY_ASSERT(a_stall_link, clk, arst_n, in_stall == (out_valid && out_stall), "stall mismatch")
	`RPY_ASSERT(a_hold, clk, arst_n, (out_valid && out_stall) |=> out_valid, "result lost while stalled")
	`RPY_ASSERT(a_fill, clk, arst_n, (!v_s1 && !v_s2 && en) |=> !v_s2, "valid invented in front stage")
	`RPY_ASSERT(a_nz_range, clk, arst_n, out_valid |-> (out_data.n_z <= 16'sd16384 && out_data.n_z >= -16'sd16384), "n_z out of range")
endmodule
